// File: hw/rtl/mlbha_pkg.sv
// Shared types, constants and arithmetic helpers of the multi-lane byte hash accumulator.
`timescale 1ns / 1ps
`default_nettype none

package mlbha_pkg;

	localparam int unsigned MAX_LANES_DEF = 1024;
	localparam int unsigned LANE_SEL_W    = 10;
	localparam int unsigned VALUE_W       = 16;
	localparam int unsigned LANE_VAL_W    = 10;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned LOG2_W        = 4;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned HASH_MOD_W    = 14;
	localparam int unsigned HASH_OFFSET   = 2;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_ABSORB = 2'd1,
		CMD_READ   = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG2  = 2'd2;

	// v' = ((byte + v + ((v + 2) >> 1)) mod 16384) + 2
	function automatic logic [VALUE_W-1:0] hash_step(input logic [VALUE_W-1:0] v,
			input logic [BYTE_W-1:0] b);
		logic [VALUE_W:0]      half;
		logic [HASH_MOD_W-1:0] sum;
		half = (17'(v) + 17'(HASH_OFFSET)) >> 1;
		sum  = HASH_MOD_W'(b) + v[HASH_MOD_W-1:0] + half[HASH_MOD_W-1:0];
		return VALUE_W'(sum) + VALUE_W'(HASH_OFFSET);
	endfunction

	// low lane_log2 bits set, saturating at the full selector width
	function automatic logic [LANE_SEL_W-1:0] lane_mask(input logic [LOG2_W-1:0] l2);
		logic [LANE_SEL_W-1:0] m;
		for (int i = 0; i < LANE_SEL_W; i++) begin
			m[i] = (LOG2_W'(i) < l2);
		end
		return m;
	endfunction

	// x mod m: a mask for power-of-two m, else restoring subtraction; only steps with m << k inside the range remain
	function automatic logic [LANE_SEL_W-1:0] lane_fold(input logic [LANE_SEL_W-1:0] x,
			input int unsigned m);
		logic [LANE_SEL_W:0] r;
		r = {1'b0, x};
		if ((m & (m - 1)) == 0) begin
			return x & LANE_SEL_W'(m - 1);
		end
		for (int k = LANE_SEL_W - 1; k >= 0; k--) begin
			if ((m << k) < (1 << LANE_SEL_W)) begin
				if (r >= (LANE_SEL_W + 1)'(m << k)) begin
					r = r - (LANE_SEL_W + 1)'(m << k);
				end
			end
		end
		return r[LANE_SEL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mlbha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mlbha_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/multi_lane_byte_hash_accumulator.sv
// Top level of the multi-lane byte hash accumulator: command pipeline around the lane RAM.
`timescale 1ns / 1ps
`default_nettype none

// One command word is taken per clock cycle, back to back, outside the clearing pass and while
// out_ready is high. Its result word is loaded into stage 1 at acceptance, together with the
// lane RAM read, and then moves on to the output register; an output stall holds it in stage 1.
// The running value and byte counter are updated at acceptance. The lane RAM is read
// at acceptance and written for absorb and write commands when the word leaves stage 1.
// A write that lands on the address being read in the same cycle is forwarded. After reset
// the lane RAM is cleared one lane per cycle with in_ready held low; configuration writes are
// taken throughout. Lane numbers from the counter or from lane_index are reduced modulo MAX_LANES.
module multi_lane_byte_hash_accumulator #(
	parameter int unsigned MAX_LANES = mlbha_pkg::MAX_LANES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mlbha_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mlbha_pkg::VALUE_W-1:0]        cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           command,
	input  wire logic [mlbha_pkg::BYTE_W-1:0]         data_byte,
	input  wire logic [mlbha_pkg::LANE_SEL_W-1:0]     lane_index,
	input  wire logic [mlbha_pkg::LANE_VAL_W-1:0]     lane_value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [mlbha_pkg::VALUE_W-1:0]        running_value,
	output logic      [mlbha_pkg::VALUE_W-1:0]        byte_count,
	output logic      [mlbha_pkg::LANE_VAL_W-1:0]     lane_data
);

	localparam int unsigned LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(MAX_LANES - 1);

	localparam int unsigned VW = mlbha_pkg::VALUE_W;
	localparam int unsigned LV = mlbha_pkg::LANE_VAL_W;

	// configuration
	logic [VW-1:0]                  seed_q;
	logic [VW-1:0]                  start_cnt_q;
	logic [mlbha_pkg::LOG2_W-1:0]   lane_log2_q;

	// architectural state outside the RAM
	logic [VW-1:0] running_q;
	logic [VW-1:0] counter_q;

	// clearing pass
	logic              clearing_q;
	logic [LANE_W-1:0] clr_addr_q;

	// stage 1
	logic                    valid_s1;
	mlbha_pkg::cmd_t         cmd_s1;
	logic [LANE_W-1:0]       addr_s1;
	logic [LV-1:0]           val_s1;
	logic [LV-1:0]           add_s1;
	logic                    fwd_hit_s1;
	logic [LV-1:0]           fwd_data_s1;
	logic [VW-1:0]           running_s1;
	logic [VW-1:0]           count_s1;

	// output register
	logic          out_valid_q;
	logic [VW-1:0] out_running_q;
	logic [VW-1:0] out_count_q;
	logic [LV-1:0] out_lane_q;

	mlbha_pkg::cmd_t                    cmd_in;
	logic                               in_fire;
	logic [VW-1:0]                      running_nx;
	logic [VW-1:0]                      counter_nx;
	logic [mlbha_pkg::LANE_SEL_W-1:0]   ctr_sel;
	logic [mlbha_pkg::LANE_SEL_W-1:0]   ctr_fold;
	logic [mlbha_pkg::LANE_SEL_W-1:0]   idx_fold;
	logic [LANE_W-1:0]                  rd_addr;
	logic [LV-1:0]                      ram_rdata;
	logic [LV-1:0]                      lane_old;
	logic [LV-1:0]                      lane_new;
	logic                               s1_adv;
	logic                               s1_wr;
	logic                               ram_wr_en;
	logic [LANE_W-1:0]                  ram_wr_addr;
	logic [LV-1:0]                      ram_wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			start_cnt_q <= '0;
			lane_log2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mlbha_pkg::CFG_SEED:  seed_q      <= cfg_data;
				mlbha_pkg::CFG_COUNT: start_cnt_q <= cfg_data;
				mlbha_pkg::CFG_LOG2:  lane_log2_q <= cfg_data[mlbha_pkg::LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	// input side
	assign cmd_in  = mlbha_pkg::cmd_t'(command);
	assign s1_adv  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clearing_q && (!valid_s1 || s1_adv);
	assign in_fire = in_valid && in_ready;

	assign ctr_sel  = counter_q[mlbha_pkg::LANE_SEL_W-1:0] & mlbha_pkg::lane_mask(lane_log2_q);
	assign ctr_fold = mlbha_pkg::lane_fold(ctr_sel, MAX_LANES);
	assign idx_fold = mlbha_pkg::lane_fold(lane_index, MAX_LANES);
	assign rd_addr  = (cmd_in == mlbha_pkg::CMD_ABSORB) ? ctr_fold[LANE_W-1:0]
			: idx_fold[LANE_W-1:0];

	always_comb begin
		running_nx = running_q;
		counter_nx = counter_q;
		unique case (cmd_in)
			mlbha_pkg::CMD_START: begin
				running_nx = seed_q;
				counter_nx = start_cnt_q;
			end
			mlbha_pkg::CMD_ABSORB: begin
				running_nx = mlbha_pkg::hash_step(running_q, data_byte);
				counter_nx = counter_q + VW'(1);
			end
			mlbha_pkg::CMD_READ,
			mlbha_pkg::CMD_WRITE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			counter_q <= '0;
		end else if (in_fire) begin
			running_q <= running_nx;
			counter_q <= counter_nx;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == LAST_LANE) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + LANE_W'(1);
			end
		end
	end

	// stage 1: lane read-modify-write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1      <= cmd_in;
			addr_s1     <= rd_addr;
			val_s1      <= lane_value;
			add_s1      <= running_nx[LV-1:0];
			running_s1  <= running_nx;
			count_s1    <= counter_nx;
			fwd_hit_s1  <= s1_wr && (addr_s1 == rd_addr);
			fwd_data_s1 <= lane_new;
		end
	end

	assign lane_old = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		unique case (cmd_s1)
			mlbha_pkg::CMD_START:  lane_new = '0;
			mlbha_pkg::CMD_ABSORB: lane_new = lane_old + add_s1;
			mlbha_pkg::CMD_READ:   lane_new = lane_old;
			mlbha_pkg::CMD_WRITE:  lane_new = val_s1;
		endcase
	end

	assign s1_wr = s1_adv
			&& (cmd_s1 == mlbha_pkg::CMD_ABSORB || cmd_s1 == mlbha_pkg::CMD_WRITE);

	assign ram_wr_en   = clearing_q || s1_wr;
	assign ram_wr_addr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wr_data = clearing_q ? '0 : lane_new;

	mlbha_ram #(
		.WIDTH (LV),
		.DEPTH (MAX_LANES)
	) u_lane_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_running_q <= running_s1;
			out_count_q   <= count_s1;
			out_lane_q    <= lane_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign running_value = out_running_q;
	assign byte_count    = out_count_q;
	assign lane_data     = out_lane_q;

	// checks
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !out_valid_q)
		else $error("pipeline active during lane clearing");

	a_absorb_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd_in == mlbha_pkg::CMD_ABSORB) |=>
			counter_q == $past(counter_q) + VW'(1))
		else $error("byte counter did not advance on absorb");

	a_absorb_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd_in == mlbha_pkg::CMD_ABSORB) |=>
			running_q >= VW'(2) && running_q <= VW'(16385))
		else $error("running value out of range after absorb");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> valid_s1 && $stable(addr_s1))
		else $error("stage 1 word lost under output stall");

endmodule

`default_nettype wire
